[hdl/bres_pkg.sv]
package bres_pkg;

   // operation codes carried in req_tuser
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   // bit positions inside the two-bit octant mode
   localparam int MODE_YMAJOR_BIT = 0;
   localparam int MODE_LEFT_BIT   = 1;

   // status flags of one result transaction
   typedef struct packed {
      logic pixel_valid;
      logic last_pixel;
      logic line_active;
   } bres_flags_type;

endpackage

[hdl/bres_datapath.sv]
// Next-state and result logic of the line walker: setup on load, one step per pixel.
module bres_datapath #(
   parameter int COORD_BITS = 11
) (
   input  logic                         op,
   input  logic [COORD_BITS-1:0]        start_x,
   input  logic [COORD_BITS-1:0]        start_y,
   input  logic [COORD_BITS-1:0]        end_x,
   input  logic [COORD_BITS-1:0]        end_y,
   input  logic [COORD_BITS-1:0]        cur_x,
   input  logic [COORD_BITS-1:0]        cur_y,
   input  logic [COORD_BITS-1:0]        stop_x,
   input  logic [COORD_BITS-1:0]        stop_y,
   input  logic [COORD_BITS-1:0]        dx_abs,
   input  logic [COORD_BITS-1:0]        dy_abs,
   input  logic signed [COORD_BITS+2:0] err,
   input  logic [1:0]                   mode,
   input  logic                         active,
   output logic [COORD_BITS-1:0]        cur_x_in,
   output logic [COORD_BITS-1:0]        cur_y_in,
   output logic [COORD_BITS-1:0]        stop_x_in,
   output logic [COORD_BITS-1:0]        stop_y_in,
   output logic [COORD_BITS-1:0]        dx_abs_in,
   output logic [COORD_BITS-1:0]        dy_abs_in,
   output logic signed [COORD_BITS+2:0] err_in,
   output logic [1:0]                   mode_in,
   output logic                         active_in,
   output logic [COORD_BITS-1:0]        pixel_x,
   output logic [COORD_BITS-1:0]        pixel_y,
   output bres_pkg::bres_flags_type     flags
);

   localparam int EW = COORD_BITS + 3;

   // load setup: order endpoints so y does not decrease
   logic                  swap;
   logic [COORD_BITS-1:0] lsx, lsy, lex, ley;
   logic [COORD_BITS-1:0] ldx, ldy;
   logic                  lleft, lxmaj;
   logic signed [EW-1:0]  lerr;

   assign swap  = start_y > end_y;
   assign lsx   = swap ? end_x   : start_x;
   assign lsy   = swap ? end_y   : start_y;
   assign lex   = swap ? start_x : end_x;
   assign ley   = swap ? start_y : end_y;
   assign ldy   = ley - lsy;
   assign lleft = lex < lsx;
   assign ldx   = lleft ? (lsx - lex) : (lex - lsx);
   assign lxmaj = ldx >= ldy;
   assign lerr  = lxmaj ? ($signed({2'b00, ldy, 1'b0}) - $signed({3'b000, ldx}))
                        : ($signed({2'b00, ldx, 1'b0}) - $signed({3'b000, ldy}));

   // step terms
   logic signed [EW-1:0]  twice_dx, twice_dy;
   logic                  err_neg, step_left, step_ymajor;
   logic [COORD_BITS-1:0] step_x, step_y;

   assign twice_dx    = $signed({2'b00, dx_abs, 1'b0});
   assign twice_dy    = $signed({2'b00, dy_abs, 1'b0});
   assign err_neg     = err[EW-1];
   assign step_left   = mode[bres_pkg::MODE_LEFT_BIT];
   assign step_ymajor = mode[bres_pkg::MODE_YMAJOR_BIT];
   assign step_x      = step_left ? (cur_x - COORD_BITS'(1)) : (cur_x + COORD_BITS'(1));
   assign step_y      = cur_y + COORD_BITS'(1);

   always_comb begin
      cur_x_in  = cur_x;
      cur_y_in  = cur_y;
      stop_x_in = stop_x;
      stop_y_in = stop_y;
      dx_abs_in = dx_abs;
      dy_abs_in = dy_abs;
      err_in    = err;
      mode_in   = mode;
      active_in = active;
      pixel_x   = '0;
      pixel_y   = '0;
      flags     = '0;
      if (op == bres_pkg::OP_LOAD) begin
         // new line replaces any line in progress
         cur_x_in  = lsx;
         cur_y_in  = lsy;
         stop_x_in = lex;
         stop_y_in = ley;
         dx_abs_in = ldx;
         dy_abs_in = ldy;
         err_in    = lerr;
         mode_in[bres_pkg::MODE_LEFT_BIT]   = lleft;
         mode_in[bres_pkg::MODE_YMAJOR_BIT] = !lxmaj;
         active_in = lxmaj ? (ldx != '0) : (ldy != '0);
         flags.line_active = active_in;
      end else if (active) begin
         // emit current pixel, then advance
         pixel_x = cur_x;
         pixel_y = cur_y;
         flags.pixel_valid = 1'b1;
         if (!step_ymajor) begin
            cur_x_in = step_x;
            if (err_neg) begin
               err_in = err + twice_dy;
            end else begin
               cur_y_in = step_y;
               err_in   = err + twice_dy - twice_dx;
            end
            flags.last_pixel = step_x == stop_x;
         end else begin
            cur_y_in = step_y;
            if (err_neg) begin
               err_in = err + twice_dx;
            end else begin
               cur_x_in = step_x;
               err_in   = err + twice_dx - twice_dy;
            end
            flags.last_pixel = step_y == stop_y;
         end
         active_in = !flags.last_pixel;
         flags.line_active = active_in;
      end
   end

endmodule

[hdl/bresenham_line_generator.sv]
// The rsp of an accepted req transaction is presented in the next cycle.
// Throughput: 1 transaction per cycle when rsp is not stalled; one load or one
// pixel step is resolved by a single add/compare level between the line state
// and the result register. Reset (synchronous, active high) clears the line
// state to idle and empties the result register.
module bresenham_line_generator #(
   parameter int COORD_BITS = 11
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // req_tdata, low bit up: start_x, start_y, end_x, end_y, zero fill
   input  logic [((4*COORD_BITS+7)/8)*8-1:0] req_tdata,
   // req_tuser: operation (0 load, 1 step)
   input  logic                req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // rsp_tdata, low bit up: pixel_x, pixel_y, line_active, zero fill
   output logic [((2*COORD_BITS+8)/8)*8-1:0] rsp_tdata,
   // rsp_tuser: pixel_valid
   output logic                rsp_tuser,
   output logic                rsp_tlast
);

   localparam int EW    = COORD_BITS + 3;
   localparam int OUT_W = ((2*COORD_BITS+8)/8)*8;

   // line state
   logic [COORD_BITS-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0] stop_x_ff, stop_x_in, stop_y_ff, stop_y_in;
   logic [COORD_BITS-1:0] dx_abs_ff, dx_abs_in, dy_abs_ff, dy_abs_in;
   logic signed [EW-1:0]  err_ff, err_in;
   logic [1:0]            mode_ff, mode_in;
   logic                  active_ff, active_in;

   // result register
   logic                  rsp_valid_ff;
   logic [OUT_W-1:0]      rsp_data_ff;
   logic                  rsp_user_ff, rsp_last_ff;

   logic                  req_fire;
   logic [COORD_BITS-1:0] pixel_x, pixel_y;
   bres_pkg::bres_flags_type flags;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   bres_datapath #(
      .COORD_BITS(COORD_BITS)
   ) u_datapath (
      .op        (req_tuser),
      .start_x   (req_tdata[COORD_BITS-1:0]),
      .start_y   (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .end_x     (req_tdata[3*COORD_BITS-1:2*COORD_BITS]),
      .end_y     (req_tdata[4*COORD_BITS-1:3*COORD_BITS]),
      .cur_x     (cur_x_ff),
      .cur_y     (cur_y_ff),
      .stop_x    (stop_x_ff),
      .stop_y    (stop_y_ff),
      .dx_abs    (dx_abs_ff),
      .dy_abs    (dy_abs_ff),
      .err       (err_ff),
      .mode      (mode_ff),
      .active    (active_ff),
      .cur_x_in  (cur_x_in),
      .cur_y_in  (cur_y_in),
      .stop_x_in (stop_x_in),
      .stop_y_in (stop_y_in),
      .dx_abs_in (dx_abs_in),
      .dy_abs_in (dy_abs_in),
      .err_in    (err_in),
      .mode_in   (mode_in),
      .active_in (active_in),
      .pixel_x   (pixel_x),
      .pixel_y   (pixel_y),
      .flags     (flags)
   );

   // state update on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff  <= '0;
         cur_y_ff  <= '0;
         stop_x_ff <= '0;
         stop_y_ff <= '0;
         dx_abs_ff <= '0;
         dy_abs_ff <= '0;
         err_ff    <= '0;
         mode_ff   <= '0;
         active_ff <= 1'b0;
      end else if (req_fire) begin
         cur_x_ff  <= cur_x_in;
         cur_y_ff  <= cur_y_in;
         stop_x_ff <= stop_x_in;
         stop_y_ff <= stop_y_in;
         dx_abs_ff <= dx_abs_in;
         dy_abs_ff <= dy_abs_in;
         err_ff    <= err_in;
         mode_ff   <= mode_in;
         active_ff <= active_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= OUT_W'({flags.line_active, pixel_y, pixel_x});
         rsp_user_ff <= flags.pixel_valid;
         rsp_last_ff <= flags.last_pixel;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // a load always answers with a non-pixel result
   a_load_result: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser == bres_pkg::OP_LOAD |=> rsp_tvalid && !rsp_tuser)
      else $error("load did not produce a non-pixel result");

   // last pixel is a real pixel and ends the line
   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser && !rsp_tdata[2*COORD_BITS])
      else $error("last pixel flagged without ending the line");

   // a step while idle returns an all-zero result
   a_idle_step: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser == bres_pkg::OP_STEP && !active_ff
      |=> !rsp_tuser && !rsp_tlast && rsp_tdata == '0)
      else $error("idle step returned a nonzero result");

   // the line can only end with a result being presented
   a_end_has_result: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(active_ff) |-> rsp_tvalid)
      else $error("line ended without a result transaction");
`endif

endmodule

[test/bresenham_line_generator_tb.sv]
`timescale 1ns / 100ps

module bresenham_line_generator_tb;

   localparam int COORD_BITS = 11;
   localparam int REQ_BITS   = ((4*COORD_BITS+7)/8)*8;
   localparam int RSP_BITS   = ((2*COORD_BITS+8)/8)*8;
   localparam int LONG_HOLD  = 40;

   typedef logic [COORD_BITS-1:0] coord_type;

   // one result transaction as seen on the rsp channel
   typedef struct packed {
      bres_pkg::bres_flags_type flags;
      coord_type                pix_x;
      coord_type                pix_y;
   } pixel_result_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   // req_tdata, low bit up: start_x, start_y, end_x, end_y, zero fill
   logic [REQ_BITS-1:0] req_tdata;
   // req_tuser: operation
   logic                req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   // rsp_tdata, low bit up: pixel_x, pixel_y, line_active, zero fill
   logic [RSP_BITS-1:0] rsp_tdata;
   // rsp_tuser: pixel_valid
   logic                rsp_tuser;
   logic                rsp_tlast;

   // line rasterizer model plus the queue of pixels still owed by the block
   class bres_scoreboard;
      coord_type        cur_x, cur_y, stop_x, stop_y;
      int               span_x, span_y;
      int               decision;
      logic [1:0]       mode;
      bit               drawing;
      pixel_result_type pending_pixels[$];
      int               errors;
      int               loads, pixels, lines_done, idle_steps;

      function void note_request(logic op, coord_type sx, coord_type sy, coord_type ex,
                                 coord_type ey);
         pixel_result_type want;
         coord_type        tmp;
         bit               left, ymajor, last;
         want = '0;
         if (op == bres_pkg::OP_LOAD) begin
            loads++;
            // y never decreases along the line
            if (sy > ey) begin
               tmp = sx; sx = ex; ex = tmp;
               tmp = sy; sy = ey; ey = tmp;
            end
            span_y = int'(ey) - int'(sy);
            left   = ex < sx;
            span_x = left ? int'(sx) - int'(ex) : int'(ex) - int'(sx);
            ymajor = span_x < span_y;
            mode[bres_pkg::MODE_LEFT_BIT]   = left;
            mode[bres_pkg::MODE_YMAJOR_BIT] = ymajor;
            decision = ymajor ? 2*span_x - span_y : 2*span_y - span_x;
            cur_x  = sx;
            cur_y  = sy;
            stop_x = ex;
            stop_y = ey;
            drawing = ymajor ? (span_y != 0) : (span_x != 0);
            want.flags.line_active = drawing;
         end else if (!drawing) begin
            idle_steps++;
         end else begin
            pixels++;
            want.flags.pixel_valid = 1'b1;
            want.pix_x = cur_x;
            want.pix_y = cur_y;
            left = mode[bres_pkg::MODE_LEFT_BIT];
            if (!mode[bres_pkg::MODE_YMAJOR_BIT]) begin
               if (decision < 0) begin
                  decision += 2*span_y;
               end else begin
                  cur_y    = cur_y + 1'b1;
                  decision += 2*span_y - 2*span_x;
               end
               cur_x = left ? cur_x - 1'b1 : cur_x + 1'b1;
               last  = cur_x == stop_x;
            end else begin
               if (decision < 0) begin
                  decision += 2*span_x;
               end else begin
                  cur_x    = left ? cur_x - 1'b1 : cur_x + 1'b1;
                  decision += 2*span_x - 2*span_y;
               end
               cur_y = cur_y + 1'b1;
               last  = cur_y == stop_y;
            end
            if (last) begin
               drawing = 1'b0;
               lines_done++;
            end
            want.flags.last_pixel  = last;
            want.flags.line_active = drawing;
         end
         pending_pixels.push_back(want);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(pixel_result_type got);
         pixel_result_type want;
         if (pending_pixels.size() == 0) begin
            $error("unexpected rsp transaction: x %0d y %0d", got.pix_x, got.pix_y);
            errors++;
         end else begin
            want = pending_pixels.pop_front();
            compare_field("pixel_valid", want.flags.pixel_valid, got.flags.pixel_valid);
            compare_field("pixel_x", want.pix_x, got.pix_x);
            compare_field("pixel_y", want.pix_y, got.pix_y);
            compare_field("last_pixel", want.flags.last_pixel, got.flags.last_pixel);
            compare_field("line_active", want.flags.line_active, got.flags.line_active);
         end
      endfunction
   endclass

   bres_scoreboard line_sb = new;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_reqs     = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int items_sent    = 0;

   bresenham_line_generator #(
      .COORD_BITS(COORD_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   // 100 MHz clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_reqs) begin
         hold_seen  <= hold_reqs;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // monitor both channels; results first, they always belong to older requests
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            line_sb.check_response('{flags: '{pixel_valid: rsp_tuser,
                                              last_pixel:  rsp_tlast,
                                              line_active: rsp_tdata[2*COORD_BITS]},
                                     pix_x: rsp_tdata[COORD_BITS-1:0],
                                     pix_y: rsp_tdata[2*COORD_BITS-1:COORD_BITS]});
         end
         if (req_tvalid && req_tready) begin
            line_sb.note_request(req_tuser,
                                 req_tdata[COORD_BITS-1:0],
                                 req_tdata[2*COORD_BITS-1:COORD_BITS],
                                 req_tdata[3*COORD_BITS-1:2*COORD_BITS],
                                 req_tdata[4*COORD_BITS-1:3*COORD_BITS]);
         end
      end
   end

   // offer one transaction, with random sender gaps before it
   task automatic send_item(input logic op, input coord_type sx, input coord_type sy,
                            input coord_type ex, input coord_type ey);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_BITS'({ey, ex, sy, sx});
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // load a line and request a given number of pixels from it
   task automatic draw_line(input coord_type sx, input coord_type sy, input coord_type ex,
                            input coord_type ey, input int steps);
      send_item(bres_pkg::OP_LOAD, sx, sy, ex, ey);
      repeat (steps) send_item(bres_pkg::OP_STEP, coord_type'($urandom),
                               coord_type'($urandom), coord_type'($urandom),
                               coord_type'($urandom));
   endtask

   // stop sending until every expected pixel has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (line_sb.pending_pixels.size() != 0) @(posedge clock);
   endtask

   function automatic int line_length(coord_type sx, coord_type sy, coord_type ex,
                                      coord_type ey);
      int dx, dy;
      dx = (ex > sx) ? ex - sx : sx - ex;
      dy = (ey > sy) ? ey - sy : sy - ey;
      return (dx > dy) ? dx : dy;
   endfunction

   function automatic coord_type near_coord(coord_type base, int reach);
      int v;
      v = int'(base) + int'($urandom_range(2*reach)) - reach;
      if (v < 0) v = 0;
      if (v > (1 << COORD_BITS) - 1) v = (1 << COORD_BITS) - 1;
      return coord_type'(v);
   endfunction

   // mostly complete lines, some cut short by a new load, some loose transactions
   task automatic random_lines(input int count);
      int        first, kind, reach;
      coord_type sx, sy, ex, ey;
      first = items_sent;
      while (items_sent - first < count) begin
         kind = $urandom_range(99);
         sx   = coord_type'($urandom);
         sy   = coord_type'($urandom);
         if (kind < 75) begin
            reach = (kind < 70) ? 16 : 150;
            ex    = near_coord(sx, reach);
            ey    = near_coord(sy, reach);
            draw_line(sx, sy, ex, ey,
                      line_length(sx, sy, ex, ey) + ($urandom_range(3) == 0));
         end else if (kind < 90) begin
            draw_line(sx, sy, coord_type'($urandom), coord_type'($urandom),
                      $urandom_range(6));
         end else begin
            send_item(1'($urandom_range(1)), sx, sy, coord_type'($urandom),
                      coord_type'($urandom));
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = bres_pkg::OP_LOAD;
      req_tdata  = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: step with no line, zero length, straight, diagonal, extremes
      send_item(bres_pkg::OP_STEP, '1, '1, '1, '1);
      draw_line(5, 5, 5, 5, 1);
      draw_line(10, 20, 13, 20, 3);
      draw_line(7, 9, 7, 6, 4);
      draw_line(20, 0, 17, 3, 3);
      draw_line(2047, 0, 0, 2047, 2);
      draw_line(1, 2, 3, 9, 7);
      drain();

      // random traffic under four idling patterns
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct     <= 0;
               hold_reqs     <= hold_reqs + 1;
            end
            1: begin
               send_idle_pct = 83;
               stall_pct     <= 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     <= 83;
            end
            default: begin
               send_idle_pct = 12;
               stall_pct     <= 12;
            end
         endcase
         random_lines(45);
         if (phase == 2) drain();
         random_lines(45);
         drain();
      end

      repeat (5) @(posedge clock);
      $display("covered %0d transactions: %0d loads, %0d pixels, %0d lines drawn to the end",
               items_sent, line_sb.loads, line_sb.pixels, line_sb.lines_done);
      $display("%0d steps with no line in progress, plus cut-short lines and a long rsp stall",
               line_sb.idle_steps);
      if (line_sb.errors == 0) begin
         $display("bresenham_line_generator: match");
      end else begin
         $display("bresenham_line_generator: mismatch");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("bresenham_line_generator: mismatch");
      $finish;
   end

endmodule

[files.f]
hdl/bres_pkg.sv
hdl/bres_datapath.sv
hdl/bresenham_line_generator.sv
test/bresenham_line_generator_tb.sv
